@@ design/fswf_pkg.sv @@
// ----------------------------------------------------------------------------
// fswf_pkg
// Shared types, constants and helpers of the fibre score window filter:
// channel words, configuration set, register indexes, reject causes and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fswf_pkg;

   // Fixed field widths of the channels and registers
   localparam int unsigned SAMPLE_W  = 12;
   localparam int unsigned CFG_W     = 12;
   localparam int unsigned COUNT_W   = 11;
   localparam int unsigned CAUSE_W   = 3;
   localparam int unsigned ORDER_W   = 3;
   localparam int unsigned CSR_IDX_W = 3;

   // Defaults of the top level parameters
   localparam int unsigned MAX_POINTS_DEF  = 1024;
   localparam int unsigned SAMPLE_BITS_DEF = 12;
   localparam int unsigned MAX_ORDER_DEF   = 4;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_POINTS    = 3'd0,
      CSR_GLOBAL_LOW    = 3'd1,
      CSR_GLOBAL_HIGH   = 3'd2,
      CSR_MEAN_LOW      = 3'd3,
      CSR_MEAN_HIGH     = 3'd4,
      CSR_POWER_LOW     = 3'd5,
      CSR_POWER_HIGH    = 3'd6,
      CSR_POWER_ORDER   = 3'd7
   } csr_index_type;

   // Reject causes, in test order
   localparam logic [CAUSE_W-1:0] CAUSE_KEPT     = 3'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_TOO_LONG = 3'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_GLOBAL   = 3'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_MEAN     = 3'd3;
   localparam logic [CAUSE_W-1:0] CAUSE_POWER    = 3'd4;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_point;
   } req_type;

   typedef struct packed {
      logic               keep;
      logic [CAUSE_W-1:0] reject_cause;
      logic [COUNT_W-1:0] point_total;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] max_points_allowed;
      logic [CFG_W-1:0]   global_low;
      logic [CFG_W-1:0]   global_high;
      logic [CFG_W-1:0]   mean_low;
      logic [CFG_W-1:0]   mean_high;
      logic [CFG_W-1:0]   power_mean_low;
      logic [CFG_W-1:0]   power_mean_high;
      logic [ORDER_W-1:0] power_order;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      max_points_allowed: 11'd1024,
      global_low:         12'd0,
      global_high:        12'd4095,
      mean_low:           12'd0,
      mean_high:          12'd4095,
      power_mean_low:     12'd0,
      power_mean_high:    12'd4095,
      power_order:        3'd1
   };

   // Which window bound the verdict sequence is working on
   typedef enum logic [1:0] {
      BND_MEAN_LO  = 2'd0,
      BND_MEAN_HI  = 2'd1,
      BND_POWER_LO = 2'd2,
      BND_POWER_HI = 2'd3
   } bnd_sel_type;

   typedef struct packed {
      logic        load_smp;
      logic        pow_step;
      logic        accumulate;
      logic        load_bnd;
      logic        scale;
      logic        result_load;
      bnd_sel_type bnd_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic order_one;
      logic pow_last;
      logic last_pt;
   } dp_status_type;

   // Exponent in force: zero reads as one, large values clip to the maximum
   function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] order,
                                                     input logic [ORDER_W-1:0] max_order);
      logic [ORDER_W-1:0] p;
      p = order;
      if (p == '0) begin
         p = ORDER_W'(1);
      end
      if (p > max_order) begin
         p = max_order;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

@@ design/fswf_csr.sv @@
// ----------------------------------------------------------------------------
// fswf_csr
// Configuration register set. Takes one write word per cycle and presents the
// full register set to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fswf_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [fswf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fswf_pkg::CFG_W-1:0]     csr_data,
   output fswf_pkg::cfg_type                   cfg
);

   fswf_pkg::cfg_type cfg_ff;
   fswf_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fswf_pkg::CSR_MAX_POINTS:  cfg_in.max_points_allowed =
                                          csr_data[fswf_pkg::COUNT_W-1:0];
            fswf_pkg::CSR_GLOBAL_LOW:  cfg_in.global_low      = csr_data;
            fswf_pkg::CSR_GLOBAL_HIGH: cfg_in.global_high     = csr_data;
            fswf_pkg::CSR_MEAN_LOW:    cfg_in.mean_low        = csr_data;
            fswf_pkg::CSR_MEAN_HIGH:   cfg_in.mean_high       = csr_data;
            fswf_pkg::CSR_POWER_LOW:   cfg_in.power_mean_low  = csr_data;
            fswf_pkg::CSR_POWER_HIGH:  cfg_in.power_mean_high = csr_data;
            fswf_pkg::CSR_POWER_ORDER: cfg_in.power_order     =
                                          csr_data[fswf_pkg::ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= fswf_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ design/fswf_dp.sv @@
// ----------------------------------------------------------------------------
// fswf_dp
// Datapath: fibre statistics, one shared multiplier for sample powers, bound
// powers and bound-times-count products, the verdict compares and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module fswf_dp #(
   parameter int unsigned MAX_POINTS  = fswf_pkg::MAX_POINTS_DEF,
   parameter int unsigned SAMPLE_BITS = fswf_pkg::SAMPLE_BITS_DEF,
   parameter int unsigned MAX_ORDER   = fswf_pkg::MAX_ORDER_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fswf_pkg::req_type       req_data,
   input  wire fswf_pkg::cfg_type       cfg,
   input  wire fswf_pkg::ctrl_cmd_type  cmd,
   output fswf_pkg::dp_status_type      status,
   output fswf_pkg::rsp_type            rsp_data
);

   localparam int unsigned CFG_W   = fswf_pkg::CFG_W;
   localparam int unsigned ORDER_W = fswf_pkg::ORDER_W;
   localparam int unsigned COUNT_W = fswf_pkg::COUNT_W;
   localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 2);
   localparam int unsigned SUM_W   = SAMPLE_BITS + $clog2(MAX_POINTS);
   localparam int unsigned PSUM_W  = SAMPLE_BITS * MAX_ORDER + $clog2(MAX_POINTS);
   localparam int unsigned PWR_W   = CFG_W * MAX_ORDER;
   localparam int unsigned MULB_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;
   localparam int unsigned MUL_W   = PWR_W + MULB_W;
   localparam int unsigned CMP_W   = (PSUM_W > MUL_W) ? PSUM_W : MUL_W;
   localparam int unsigned LEN_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic [CFG_W-1:0]       base_ff,  base_in;
   logic [PWR_W-1:0]       pw_ff,    pw_in;
   logic [ORDER_W-1:0]     exp_ff,   exp_in;
   logic                   last_ff,  last_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SAMPLE_BITS-1:0] min_ff,   min_in;
   logic [SAMPLE_BITS-1:0] max_ff,   max_in;
   logic [SUM_W-1:0]       sum_ff,   sum_in;
   logic [PSUM_W-1:0]      psum_ff,  psum_in;
   logic [MUL_W-1:0]       lim_ff [4];
   fswf_pkg::rsp_type      rsp_ff,   rsp_in;

   logic [SAMPLE_BITS-1:0] smp;
   logic [SAMPLE_BITS-1:0] acc_smp;
   logic [ORDER_W-1:0]     order;
   logic [CFG_W-1:0]       bound;
   logic [MULB_W-1:0]      mul_b;
   logic [MUL_W-1:0]       mul_p;
   logic                   too_long;
   logic                   out_global;
   logic                   out_mean;
   logic                   out_power;
   logic [fswf_pkg::CAUSE_W-1:0] cause;

   assign smp     = req_data.sample[SAMPLE_BITS-1:0];
   assign acc_smp = base_ff[SAMPLE_BITS-1:0];
   assign order   = fswf_pkg::eff_order(cfg.power_order, ORDER_W'(MAX_ORDER));

   // bound picked for the verdict sequence
   always_comb begin
      unique case (cmd.bnd_sel)
         fswf_pkg::BND_MEAN_LO:  bound = cfg.mean_low;
         fswf_pkg::BND_MEAN_HI:  bound = cfg.mean_high;
         fswf_pkg::BND_POWER_LO: bound = cfg.power_mean_low;
         fswf_pkg::BND_POWER_HI: bound = cfg.power_mean_high;
         default:                bound = cfg.mean_low;
      endcase
   end

   // shared multiplier: power step by the base, or scale by the point count
   assign mul_b = cmd.scale ? MULB_W'(count_ff) : MULB_W'(base_ff);
   assign mul_p = pw_ff * mul_b;

   // status back to the controller
   assign status.order_one = (order == ORDER_W'(1));
   assign status.pow_last  = (({1'b0, exp_ff} + (ORDER_W + 1)'(1)) >= {1'b0, order});
   assign status.last_pt   = last_ff;

   // verdict tests, first failing one wins
   assign too_long   = (LEN_W'(count_ff) > LEN_W'(cfg.max_points_allowed)) ||
                       (count_ff > CNT_W'(MAX_POINTS));
   assign out_global = (CFG_W'(min_ff) < cfg.global_low) ||
                       (CFG_W'(max_ff) > cfg.global_high);
   assign out_mean   = (CMP_W'(sum_ff) < CMP_W'(lim_ff[fswf_pkg::BND_MEAN_LO])) ||
                       (CMP_W'(sum_ff) > CMP_W'(lim_ff[fswf_pkg::BND_MEAN_HI]));
   assign out_power  = (CMP_W'(psum_ff) < CMP_W'(lim_ff[fswf_pkg::BND_POWER_LO])) ||
                       (CMP_W'(psum_ff) > CMP_W'(lim_ff[fswf_pkg::BND_POWER_HI]));

   always_comb begin
      if (too_long) begin
         cause = fswf_pkg::CAUSE_TOO_LONG;
      end else if (out_global) begin
         cause = fswf_pkg::CAUSE_GLOBAL;
      end else if (out_mean) begin
         cause = fswf_pkg::CAUSE_MEAN;
      end else if (out_power) begin
         cause = fswf_pkg::CAUSE_POWER;
      end else begin
         cause = fswf_pkg::CAUSE_KEPT;
      end
   end

   // operand and power registers
   always_comb begin
      base_in = base_ff;
      pw_in   = pw_ff;
      exp_in  = exp_ff;
      last_in = last_ff;
      if (cmd.load_smp) begin
         base_in = CFG_W'(smp);
         pw_in   = PWR_W'(smp);
         exp_in  = ORDER_W'(1);
         last_in = req_data.last_point;
      end else if (cmd.load_bnd) begin
         base_in = bound;
         pw_in   = PWR_W'(bound);
         exp_in  = ORDER_W'(1);
      end else if (cmd.pow_step) begin
         pw_in  = mul_p[PWR_W-1:0];
         exp_in = exp_ff + ORDER_W'(1);
      end
   end

   // fibre statistics; cleared once the verdict word is loaded
   always_comb begin
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      psum_in  = psum_ff;
      if (cmd.result_load) begin
         count_in = '0;
         min_in   = '1;
         max_in   = '0;
         sum_in   = '0;
         psum_in  = '0;
      end else if (cmd.accumulate) begin
         if (count_ff < CNT_W'(MAX_POINTS)) begin
            if (acc_smp < min_ff) begin
               min_in = acc_smp;
            end
            if (acc_smp > max_ff) begin
               max_in = acc_smp;
            end
            sum_in  = sum_ff + SUM_W'(acc_smp);
            psum_in = psum_ff + PSUM_W'(pw_ff);
         end
         if (count_ff <= CNT_W'(MAX_POINTS)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // result word
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.result_load) begin
         rsp_in.keep         = (cause == fswf_pkg::CAUSE_KEPT);
         rsp_in.reject_cause = cause;
         rsp_in.point_total  = COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         sum_ff   <= '0;
         psum_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         psum_ff  <= psum_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      pw_ff   <= pw_in;
      exp_ff  <= exp_in;
      rsp_ff  <= rsp_in;
      if (cmd.scale) begin
         lim_ff[cmd.bnd_sel] <= mul_p;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ design/fswf_ctrl.sv @@
// ----------------------------------------------------------------------------
// fswf_ctrl
// Controller: sequences sample powering, accumulation and, on a fibre's last
// point, the bound products and the verdict. Owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module fswf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire fswf_pkg::dp_status_type status,
   output fswf_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_POW   = 7'b0000010,
      ST_ACC   = 7'b0000100,
      ST_LOAD  = 7'b0001000,
      ST_BPOW  = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   fswf_pkg::bnd_sel_type sel_ff,   sel_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.bnd_sel = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_smp = 1'b1;
               state_in     = status.order_one ? ST_ACC : ST_POW;
            end
         end
         ST_POW: begin
            cmd.pow_step = 1'b1;
            if (status.pow_last) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            if (status.last_pt) begin
               sel_in   = fswf_pkg::BND_MEAN_LO;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load_bnd = 1'b1;
            if (sel_ff == fswf_pkg::BND_MEAN_LO || sel_ff == fswf_pkg::BND_MEAN_HI ||
                status.order_one) begin
               state_in = ST_SCALE;
            end else begin
               state_in = ST_BPOW;
            end
         end
         ST_BPOW: begin
            cmd.pow_step = 1'b1;
            if (status.pow_last) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            if (sel_ff == fswf_pkg::BND_POWER_HI) begin
               state_in = ST_DONE;
            end else begin
               sel_in   = fswf_pkg::bnd_sel_type'(sel_ff + 2'd1);
               state_in = ST_LOAD;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word valid
   assign rsp_valid_in = cmd.result_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= fswf_pkg::BND_MEAN_LO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ design/fiber_score_window_filter.sv @@
// ----------------------------------------------------------------------------
// fiber_score_window_filter
// Fibre selection by score windows: one sample word per point, one verdict
// word per fibre, a csr port for the eight window and limit registers.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one sample per word; last_point closes the fibre.
//   rsp_*  carries one verdict word per fibre (keep, cause, point total).
//   csr_*  writes register csr_index with csr_data; always ready. Write it
//          only while no fibre is in flight.
// Sequence, with p the power order in force (1..MAX_ORDER):
//   A point that is not last occupies the block for the accept step, p-1
//   passes through the shared multiplier and an accumulate step.
//   A last point runs the same steps, then mean bound times count for both
//   mean bounds, then bound^p times count for each power bound, all on the
//   one multiplier, then a decide step that loads the verdict word.
// Reset: synchronous; clears the statistics, the verdict valid and loads the
//   register defaults. No clearing pass is needed.
// Stalls: the verdict sits in an output register, so the next fibre is taken
//   while it waits; only a second verdict holds the block in its decide cycle
//   until rsp_ready frees the register.
// ----------------------------------------------------------------------------
`default_nettype none

module fiber_score_window_filter #(
   parameter int unsigned MAX_POINTS  = fswf_pkg::MAX_POINTS_DEF,
   parameter int unsigned SAMPLE_BITS = fswf_pkg::SAMPLE_BITS_DEF,
   parameter int unsigned MAX_ORDER   = fswf_pkg::MAX_ORDER_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire fswf_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output fswf_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [fswf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fswf_pkg::CFG_W-1:0]     csr_data
);

   fswf_pkg::cfg_type       cfg;
   fswf_pkg::ctrl_cmd_type  cmd;
   fswf_pkg::dp_status_type status;

   fswf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fswf_dp #(
      .MAX_POINTS  (MAX_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_ORDER   (MAX_ORDER)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   fswf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // a sample word is worked on before the next is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample word taken while previous one still in work");

   // keep flag agrees with the cause code
   a_keep_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.keep == (rsp_data.reject_cause == fswf_pkg::CAUSE_KEPT)))
      else $error("keep flag disagrees with reject cause");

   // a verdict always counts the closing point
   a_nonzero_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.point_total != '0))
      else $error("verdict with zero points");

   // a new verdict only loads into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("pending verdict overwritten");

endmodule

`default_nettype wire

@@ tb/sv/tb_fiber_score_window_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fiber_score_window_filter
// Self-checking bench for the fibre score window filter. Sample words go in
// through a queue-fed driver; a shadow copy of the eight registers and of the
// per-fibre statistics predicts each verdict word, which the monitor checks
// as a whole and in order. Directed fibres hit the window edges and every
// reject cause, then randomised fibres run under a series of register
// settings with random idling, a long output stall and a saturated fibre.
// ----------------------------------------------------------------------------

module tb_fiber_score_window_filter;

   localparam int unsigned MAX_POINTS      = fswf_pkg::MAX_POINTS_DEF;
   localparam int unsigned MAX_ORDER       = fswf_pkg::MAX_ORDER_DEF;
   localparam int unsigned SETTLE_CYCLES   = 40;
   localparam int unsigned RUN_LIMIT       = 1000000;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned MISMATCH_PRINTS = 10;
   localparam int unsigned PHASE_WORDS     = 90;

   // DUT connections; the driven ones known from time zero
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   fswf_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   fswf_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [fswf_pkg::CSR_IDX_W-1:0] csr_index = fswf_pkg::CSR_MAX_POINTS;
   logic [fswf_pkg::CFG_W-1:0]     csr_data  = '0;

   // Stimulus and expectation stores
   fswf_pkg::req_type sample_words[$];
   fswf_pkg::rsp_type expected_verdicts[$];

   // Shadow registers, reset values as documented for the block
   fswf_pkg::cfg_type wcfg = '{
      max_points_allowed: 11'd1024,
      global_low:         12'd0,
      global_high:        12'd4095,
      mean_low:           12'd0,
      mean_high:          12'd4095,
      power_mean_low:     12'd0,
      power_mean_high:    12'd4095,
      power_order:        3'd1
   };

   // Statistics of the fibre being received
   int unsigned       pt_count     = 0;
   logic [fswf_pkg::SAMPLE_W-1:0] pt_min = '1;
   logic [fswf_pkg::SAMPLE_W-1:0] pt_max = '0;
   longint unsigned   pt_sum       = 0;
   longint unsigned   pt_power_sum = 0;

   // Idling controls and bookkeeping
   int unsigned send_gap_max = 8;
   int unsigned recv_gap_max = 8;
   int unsigned send_wait    = 0;
   int unsigned recv_wait    = 0;
   int unsigned hold_left    = 0;
   logic        hold_go      = 1'b0;
   logic        hold_used    = 1'b0;
   int unsigned cycle_count  = 0;
   int unsigned failures     = 0;
   int unsigned words_taken  = 0;
   int unsigned verdicts_seen = 0;
   int unsigned cause_seen[0:7];

   fiber_score_window_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Exponent in force: zero reads as one, clipped at the maximum order
   function automatic int unsigned order_in_force();
      int unsigned p;
      p = wcfg.power_order;
      if (p == 0) p = 1;
      if (p > MAX_ORDER) p = MAX_ORDER;
      return p;
   endfunction

   function automatic longint unsigned raise_to(input longint unsigned b,
                                                 input int unsigned p);
      longint unsigned r;
      r = 1;
      for (int unsigned i = 0; i < p; i++) r = r * b;
      return r;
   endfunction

   // Fold one accepted sample word into the fibre statistics; on the last
   // point work out the verdict and start a fresh fibre
   function automatic void fold_point(input fswf_pkg::req_type w);
      longint unsigned n;
      int unsigned     p;
      logic [fswf_pkg::CAUSE_W-1:0] cause;
      fswf_pkg::rsp_type v;
      if (pt_count < MAX_POINTS) begin
         if (w.sample < pt_min) pt_min = w.sample;
         if (w.sample > pt_max) pt_max = w.sample;
         pt_sum       += w.sample;
         pt_power_sum += raise_to(w.sample, order_in_force());
      end
      // count saturates one past the point limit
      if (pt_count <= MAX_POINTS) pt_count++;
      if (w.last_point) begin
         n = pt_count;
         p = order_in_force();
         if (pt_count > wcfg.max_points_allowed || pt_count > MAX_POINTS)
            cause = fswf_pkg::CAUSE_TOO_LONG;
         else if (pt_min < wcfg.global_low || pt_max > wcfg.global_high)
            cause = fswf_pkg::CAUSE_GLOBAL;
         else if (pt_sum < longint'(wcfg.mean_low) * n ||
                  pt_sum > longint'(wcfg.mean_high) * n)
            cause = fswf_pkg::CAUSE_MEAN;
         else if (pt_power_sum < raise_to(wcfg.power_mean_low, p) * n ||
                  pt_power_sum > raise_to(wcfg.power_mean_high, p) * n)
            cause = fswf_pkg::CAUSE_POWER;
         else
            cause = fswf_pkg::CAUSE_KEPT;
         v.keep         = (cause == fswf_pkg::CAUSE_KEPT);
         v.reject_cause = cause;
         v.point_total  = fswf_pkg::COUNT_W'(pt_count);
         expected_verdicts.insert(expected_verdicts.size(), v);
         pt_count     = 0;
         pt_min       = '1;
         pt_max       = '0;
         pt_sum       = 0;
         pt_power_sum = 0;
      end
   endfunction

   // Driver: offers queued sample words, idling a drawn number of cycles
   always @(posedge clock) begin
      int unsigned wait_now;
      logic        on_offer;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         on_offer = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            fold_point(req_data);
            words_taken++;
            wait_now = $urandom_range(0, send_gap_max);
         end else begin
            wait_now = send_wait;
         end
         if (!on_offer) begin
            if (wait_now != 0) begin
               req_valid <= 1'b0;
               send_wait <= wait_now - 1;
            end else if (sample_words.size() != 0) begin
               req_data  <= sample_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long output stall, counted here once triggered
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: takes verdict words and checks them against the oldest expected
   always @(posedge clock) begin
      int unsigned       wait_now;
      fswf_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            cause_seen[rsp_data.reject_cause]++;
            if (expected_verdicts.size() == 0) begin
               failures++;
               if (failures <= MISMATCH_PRINTS)
                  $display("unexpected verdict word: keep %0d cause %0d total %0d",
                           rsp_data.keep, rsp_data.reject_cause, rsp_data.point_total);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data !== want) begin
                  failures++;
                  if (failures <= MISMATCH_PRINTS)
                     $display({"verdict mismatch: expected keep %0d cause %0d total %0d,",
                               " got keep %0d cause %0d total %0d"},
                              want.keep, want.reject_cause, want.point_total,
                              rsp_data.keep, rsp_data.reject_cause, rsp_data.point_total);
               end
            end
            wait_now = $urandom_range(0, recv_gap_max);
         end else begin
            wait_now = recv_wait;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            recv_wait <= wait_now;
         end else if (wait_now != 0) begin
            rsp_ready <= 1'b0;
            recv_wait <= wait_now - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("fiber_score_window_filter regression: fail");
         $finish;
      end
   end

   function automatic int clip12(input int v);
      return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
   endfunction

   function automatic void push_word(input int unsigned s, input logic last);
      fswf_pkg::req_type w;
      w.sample     = s[fswf_pkg::SAMPLE_W-1:0];
      w.last_point = last;
      sample_words.insert(sample_words.size(), w);
   endfunction

   // Fibre of random samples spread around a centre
   function automatic void push_fiber(input int unsigned len, input int centre,
                                      input int unsigned spread);
      int s;
      for (int unsigned i = 0; i < len; i++) begin
         s = clip12(centre + int'($urandom_range(0, 2 * spread)) - int'(spread));
         push_word(s, i == len - 1);
      end
   endfunction

   // Wait until every word is taken and every verdict is in, then let the
   // block finish any internal work
   task automatic settle_all();
      while (sample_words.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input fswf_pkg::csr_index_type idx, input int unsigned val);
      csr_index <= idx;
      csr_data  <= val[fswf_pkg::CFG_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      // mirror the write into the shadow registers, masked as the block does
      case (idx)
         fswf_pkg::CSR_MAX_POINTS:  wcfg.max_points_allowed = val[fswf_pkg::COUNT_W-1:0];
         fswf_pkg::CSR_GLOBAL_LOW:  wcfg.global_low         = val[fswf_pkg::CFG_W-1:0];
         fswf_pkg::CSR_GLOBAL_HIGH: wcfg.global_high        = val[fswf_pkg::CFG_W-1:0];
         fswf_pkg::CSR_MEAN_LOW:    wcfg.mean_low           = val[fswf_pkg::CFG_W-1:0];
         fswf_pkg::CSR_MEAN_HIGH:   wcfg.mean_high          = val[fswf_pkg::CFG_W-1:0];
         fswf_pkg::CSR_POWER_LOW:   wcfg.power_mean_low     = val[fswf_pkg::CFG_W-1:0];
         fswf_pkg::CSR_POWER_HIGH:  wcfg.power_mean_high    = val[fswf_pkg::CFG_W-1:0];
         fswf_pkg::CSR_POWER_ORDER: wcfg.power_order        = val[fswf_pkg::ORDER_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_windows(input int unsigned mp, input int unsigned gl,
                                input int unsigned gh, input int unsigned ml,
                                input int unsigned mh, input int unsigned pl,
                                input int unsigned ph, input int unsigned ord);
      csr_put(fswf_pkg::CSR_MAX_POINTS, mp);
      csr_put(fswf_pkg::CSR_GLOBAL_LOW, gl);
      csr_put(fswf_pkg::CSR_GLOBAL_HIGH, gh);
      csr_put(fswf_pkg::CSR_MEAN_LOW, ml);
      csr_put(fswf_pkg::CSR_MEAN_HIGH, mh);
      csr_put(fswf_pkg::CSR_POWER_LOW, pl);
      csr_put(fswf_pkg::CSR_POWER_HIGH, ph);
      csr_put(fswf_pkg::CSR_POWER_ORDER, ord);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int          centre;
      int unsigned phase_words;
      int unsigned len;
      int unsigned mp;
      int unsigned ord;
      int unsigned wide;

      foreach (cause_seen[i]) cause_seen[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: extreme samples, single and two-point fibres
      push_word(0, 1'b1);
      push_word(4095, 1'b1);
      push_word(0, 1'b0);
      push_word(4095, 1'b1);
      settle_all();

      // Point limit of zero rejects everything
      apply_windows(0, 0, 4095, 0, 4095, 0, 4095, 1);
      push_word(7, 1'b1);
      settle_all();

      // Global and mean window edges, order zero read as one, length limit
      apply_windows(3, 100, 200, 120, 180, 0, 4095, 0);
      push_word(100, 1'b0);
      push_word(200, 1'b1);
      push_word(99, 1'b1);
      push_word(201, 1'b1);
      push_word(100, 1'b0);
      push_word(100, 1'b1);
      push_word(100, 1'b0);
      push_word(110, 1'b0);
      push_word(120, 1'b0);
      push_word(130, 1'b1);
      settle_all();

      // Power window with the order clipped to the maximum
      apply_windows(1024, 0, 4095, 0, 4095, 150, 160, 7);
      push_word(150, 1'b1);
      push_word(100, 1'b0);
      push_word(200, 1'b1);
      push_word(161, 1'b1);
      settle_all();

      // Inverted windows reject whatever arrives
      apply_windows(1024, 300, 200, 0, 4095, 0, 4095, 1);
      push_word(250, 1'b1);
      settle_all();
      apply_windows(1024, 0, 4095, 300, 200, 0, 4095, 1);
      push_word(250, 1'b1);
      settle_all();
      apply_windows(1024, 0, 4095, 0, 4095, 300, 200, 1);
      push_word(250, 1'b1);
      settle_all();

      // Randomised phases, each under its own register setting
      for (int unsigned phase = 0; phase < 8; phase++) begin
         centre = (phase == 0) ? 0 : (phase == 1) ? 4095 : $urandom_range(0, 4095);
         ord    = (phase < 5) ? phase : $urandom_range(0, 7);
         mp     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                              : $urandom_range(13, 4095);
         if (phase == 2)
            apply_windows(4095, 0, 4095, 0, 4095, 0, 4095, 4);
         else
            apply_windows(mp,
                          clip12(centre - int'($urandom_range(200, 1500))),
                          clip12(centre + int'($urandom_range(200, 1500))),
                          clip12(centre - int'($urandom_range(0, 400))),
                          clip12(centre + int'($urandom_range(0, 400))),
                          clip12(centre - int'($urandom_range(0, 400))),
                          clip12(centre + int'($urandom_range(0, 600))),
                          ord);
         send_gap_max <= (phase % 3 == 1) ? 0 : 8;
         recv_gap_max <= (phase % 3 == 1) ? 0 : 8;
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: short fibre anywhere in the sample range
               len = $urandom_range(1, 6);
               push_fiber(len, 2048, 2048);
            end else begin
               len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
                                                  : $urandom_range(1, 10);
               wide = $urandom_range(0, 400);
               push_fiber(len, centre + int'($urandom_range(0, 600)) - 300, wide);
            end
            phase_words += len;
         end
         // long output stall while the sender keeps offering
         if (phase == 5) hold_go <= 1'b1;
         settle_all();
      end

      // Fibre running past the point limit, so the count saturates
      send_gap_max <= 2;
      recv_gap_max <= 2;
      apply_windows(4095, 0, 4095, 0, 4095, 0, 4095, 3);
      push_fiber(MAX_POINTS + 6, 2048, 2047);
      settle_all();

      if (expected_verdicts.size() != 0) begin
         failures += expected_verdicts.size();
         $display("%0d expected verdict words never arrived", expected_verdicts.size());
      end
      $display("run covered %0d sample words and %0d fibre verdicts", words_taken,
               verdicts_seen);
      $display("verdicts: kept %0d, too long %0d, global %0d, mean %0d, power mean %0d",
               cause_seen[fswf_pkg::CAUSE_KEPT], cause_seen[fswf_pkg::CAUSE_TOO_LONG],
               cause_seen[fswf_pkg::CAUSE_GLOBAL], cause_seen[fswf_pkg::CAUSE_MEAN],
               cause_seen[fswf_pkg::CAUSE_POWER]);
      if (failures == 0) begin
         $display("fiber_score_window_filter regression: pass");
      end else begin
         $display("fiber_score_window_filter regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/fswf_pkg.sv
design/fswf_csr.sv
design/fswf_dp.sv
design/fswf_ctrl.sv
design/fiber_score_window_filter.sv
tb/sv/tb_fiber_score_window_filter.sv
